// ===== rtl/bracket_balance_checker_defines.svh =====
// Assertion macros shared by the bracket balance checker RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bracket balance checker: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bracket balance checker: next-cycle check failed");

`endif

// ===== rtl/bbc_pkg.sv =====
// Types, status codes and character decoding for the bracket balance checker.
// No dependencies; imported by the top level.
`default_nettype none

package bbc_pkg;

  typedef logic [2:0] status_t;
  typedef logic [1:0] kind_t;

  localparam status_t ST_BUSY     = 3'd0;
  localparam status_t ST_EXTRA    = 3'd1;
  localparam status_t ST_MISMATCH = 3'd2;
  localparam status_t ST_LACKING  = 3'd3;
  localparam status_t ST_BALANCED = 3'd4;
  localparam status_t ST_OVERFLOW = 3'd5;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_CURLY  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // ')'
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // '}'
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ']'

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_OPEN,
    CLS_CLOSE
  } cls_t;

  typedef struct packed {
    cls_t  cls;
    kind_t kind;
  } decode_t;

  function automatic decode_t bbc_decode(input logic [7:0] ch);
    decode_t d;
    d.cls  = CLS_NONE;
    d.kind = KIND_ROUND;
    case (ch)
      CH_OPEN_ROUND: begin
        d.cls  = CLS_OPEN;
        d.kind = KIND_ROUND;
      end
      CH_OPEN_CURLY: begin
        d.cls  = CLS_OPEN;
        d.kind = KIND_CURLY;
      end
      CH_OPEN_SQUARE: begin
        d.cls  = CLS_OPEN;
        d.kind = KIND_SQUARE;
      end
      CH_CLOSE_ROUND: begin
        d.cls  = CLS_CLOSE;
        d.kind = KIND_ROUND;
      end
      CH_CLOSE_CURLY: begin
        d.cls  = CLS_CLOSE;
        d.kind = KIND_CURLY;
      end
      CH_CLOSE_SQUARE: begin
        d.cls  = CLS_CLOSE;
        d.kind = KIND_SQUARE;
      end
      default: begin
        d.cls  = CLS_NONE;
        d.kind = KIND_ROUND;
      end
    endcase
    return d;
  endfunction

  function automatic logic [7:0] bbc_closer(input kind_t k);
    logic [7:0] c;
    case (k)
      KIND_ROUND:  c = CH_CLOSE_ROUND;
      KIND_CURLY:  c = CH_CLOSE_CURLY;
      KIND_SQUARE: c = CH_CLOSE_SQUARE;
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bbc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the bracket stack.
`default_nettype none

module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// Bracket balance checker: one character per request, one result per request.
// Throughput is one request per cycle unless out_stall holds the pipeline; it is
// set by the single stack RAM read/write per cycle. Stack pointer updates in the
// first stage; the popped kind comes from the RAM's registered read and is
// compared in the second stage.
// Reset (rst, synchronous) empties the pipeline, stack and error state.
`default_nettype none
`include "bracket_balance_checker_defines.svh"

module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      status,
  output logic [7:0]      expected_char,
  output logic            expr_done
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] PTR_FULL = PW'(STACK_DEPTH);

  // Stage one: pointer bookkeeping.
  logic [PW-1:0] ptr;
  logic [PW-1:0] ptr_next;
  logic [PW-1:0] ptr_dec;
  decode_t       dec;
  logic          in_acc;
  logic          is_push;
  logic          is_pop;
  logic          is_ovf;
  logic          is_extra;

  logic          s1_valid;
  logic          s1_pop;
  logic          s1_ovf;
  logic          s1_extra;
  logic          s1_empty;
  logic          s1_last;
  kind_t         s1_kind;

  // Stage two: error merge and result.
  logic          s2_adv;
  kind_t         ram_rdata;
  status_t       error_latched;
  kind_t         err_kind;
  status_t       err_next;
  kind_t         err_kind_next;
  status_t       status_next;
  logic [7:0]    expected_next;

  assign in_acc   = in_valid & ~in_stall;
  assign s2_adv   = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & out_valid & out_stall;

  assign dec      = bbc_decode(char_in);
  assign is_push  = (dec.cls == CLS_OPEN) && (ptr != PTR_FULL);
  assign is_ovf   = (dec.cls == CLS_OPEN) && (ptr == PTR_FULL);
  assign is_pop   = (dec.cls == CLS_CLOSE) && (ptr != '0);
  assign is_extra = (dec.cls == CLS_CLOSE) && (ptr == '0);
  assign ptr_dec  = ptr - PW'(1);

  always_comb begin
    ptr_next = ptr;
    if (is_push) begin
      ptr_next = ptr + PW'(1);
    end else if (is_pop) begin
      ptr_next = ptr_dec;
    end
  end

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (in_acc & is_push),
    .waddr (ptr[AW-1:0]),
    .wdata (dec.kind),
    .re    (in_acc & is_pop),
    .raddr (ptr_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Only the first error of an expression counts; requests after it may still
  // move the pointer, but their events are dropped here.
  always_comb begin
    err_next      = error_latched;
    err_kind_next = err_kind;
    if (error_latched == ST_BUSY) begin
      if (s1_ovf) begin
        err_next = ST_OVERFLOW;
      end else if (s1_extra) begin
        err_next = ST_EXTRA;
      end else if (s1_pop && (ram_rdata != s1_kind)) begin
        err_next      = ST_MISMATCH;
        err_kind_next = ram_rdata;
      end
    end
    if (err_next != ST_BUSY) begin
      status_next = err_next;
    end else if (s1_last) begin
      status_next = s1_empty ? ST_BALANCED : ST_LACKING;
    end else begin
      status_next = ST_BUSY;
    end
    expected_next = (err_next == ST_MISMATCH) ? bbc_closer(err_kind_next) : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr           <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      error_latched <= ST_BUSY;
      err_kind      <= KIND_ROUND;
    end else begin
      if (in_acc) begin
        ptr      <= is_last ? '0 : ptr_next;
        s1_valid <= 1'b1;
      end else if (s2_adv) begin
        s1_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid     <= 1'b1;
        error_latched <= s1_last ? ST_BUSY : err_next;
        err_kind      <= s1_last ? KIND_ROUND : err_kind_next;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pop   <= is_pop;
      s1_ovf   <= is_ovf;
      s1_extra <= is_extra;
      s1_empty <= (ptr_next == '0);
      s1_last  <= is_last;
      s1_kind  <= dec.kind;
    end
    if (s2_adv) begin
      status        <= status_next;
      expected_char <= expected_next;
      expr_done     <= s1_last;
    end
  end

  `BBC_ASSERT_IMPL(a_ptr_range, clk, rst, 1'b1, ptr <= PTR_FULL)
  `BBC_ASSERT_IMPL(a_err_codes, clk, rst, 1'b1,
    error_latched == ST_BUSY || error_latched == ST_EXTRA ||
    error_latched == ST_MISMATCH || error_latched == ST_OVERFLOW)
  `BBC_ASSERT_IMPL(a_expect_only_mismatch, clk, rst,
    out_valid && (expected_char != 8'h00), status == ST_MISMATCH)
  `BBC_ASSERT_NEXT(a_clear_after_last, clk, rst, s2_adv && s1_last,
    error_latched == ST_BUSY)

endmodule

`default_nettype wire
